// ===== sv/mtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media timestamp reviser package
// Shared widths, constants, item types, register indexes and the saturating
// adder used by the timestamp revision logic.
// ----------------------------------------------------------------------------
package mtr_pkg;

    localparam int STAMP_BITS     = 48;
    localparam int OUT_BITS       = 48;
    localparam int RAW_BITS       = 32;
    localparam int JUMP_BITS      = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 20;
    localparam int GAP_LIMIT      = 500;
    localparam int JUMP_RESET     = 300;

    typedef logic signed [STAMP_BITS-1:0] stamp_t;
    typedef logic signed [RAW_BITS:0]     raw_diff_t;

    localparam stamp_t    STAMP_MAX = {1'b0, {(STAMP_BITS-1){1'b1}}};
    localparam stamp_t    STAMP_MIN = {1'b1, {(STAMP_BITS-1){1'b0}}};
    localparam raw_diff_t GAP_HI    = raw_diff_t'(GAP_LIMIT);
    localparam raw_diff_t GAP_LO    = -raw_diff_t'(GAP_LIMIT);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PLAYBACK       = 2'd0,
        CFG_ALLOW_ROLLBACK = 2'd1,
        CFG_MAX_JUMP       = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                 playback;
        logic                 allow_rollback;
        logic [JUMP_BITS-1:0] max_jump;
    } cfg_t;

    typedef struct packed {
        logic [RAW_BITS-1:0] decode_time;
        logic [RAW_BITS-1:0] present_time;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] decode_out;
        logic signed [OUT_BITS-1:0] present_out;
    } out_item_t;

    // Adds a delta to a stamp and clamps the result to the signed stamp range.
    function automatic stamp_t sat_add(input stamp_t a, input stamp_t d);
        logic signed [STAMP_BITS:0] sum;
        stamp_t                     res;
        sum = {a[STAMP_BITS-1], a} + {d[STAMP_BITS-1], d};
        if (sum[STAMP_BITS] != sum[STAMP_BITS-1]) begin
            res = sum[STAMP_BITS] ? STAMP_MIN : STAMP_MAX;
        end else begin
            res = sum[STAMP_BITS-1:0];
        end
        return res;
    endfunction

    // Sign-extends or truncates a stamp to the output field width.
    function automatic logic signed [OUT_BITS-1:0] to_out(input stamp_t s);
        logic signed [63:0] wide;
        wide = 64'(s);
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

// ===== sv/media_timestamp_reviser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media timestamp reviser
// Rewrites frame decode and presentation timestamps into a monotonic
// relative timeline, with pass-through playback mode.
// ----------------------------------------------------------------------------
// The block takes one timestamp item per clock cycle while in_stall is low
// and returns one result item for each through the result register.
// The whole revision of an item, including the update of the stamp history,
// happens combinationally between the input register and the result
// register, so the stamp history update loop sets the rate. The result register
// lets a new item enter while a finished result still waits to be taken.
// Configuration must be written only while no item is in flight.
module media_timestamp_reviser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mtr_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mtr_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [mtr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mtr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import mtr_pkg::*;

    cfg_t      cfg;
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;
    logic      in_fire;

    mtr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mtr_revise u_revise (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_item_reg <= in_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the result register");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("waiting input item was lost or changed");

endmodule

// ===== sv/mtr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media timestamp reviser configuration registers
// Holds the playback, rollback and maximum jump settings written through the
// plain write port.
// ----------------------------------------------------------------------------
module mtr_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mtr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mtr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output mtr_pkg::cfg_t                        cfg
);
    import mtr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_PLAYBACK:       cfg_next.playback       = cfg_wdata[0];
                CFG_ALLOW_ROLLBACK: cfg_next.allow_rollback = cfg_wdata[0];
                CFG_MAX_JUMP:       cfg_next.max_jump       = cfg_wdata[JUMP_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.playback       <= 1'b0;
            cfg_reg.allow_rollback <= 1'b0;
            cfg_reg.max_jump       <= JUMP_BITS'(JUMP_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/mtr_revise.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media timestamp reviser datapath
// Holds the stamp history and computes one revised timestamp pair per item
// from the registered input item in a single pass.
// ----------------------------------------------------------------------------
module mtr_revise (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  mtr_pkg::in_item_t  item,
    input  mtr_pkg::cfg_t      cfg,
    output mtr_pkg::out_item_t result
);
    import mtr_pkg::*;

    logic [RAW_BITS-1:0]  prev_raw_reg,  prev_raw_next;
    logic [JUMP_BITS-1:0] last_good_reg, last_good_next;
    stamp_t               running_reg,   running_next;
    logic [RAW_BITS-1:0]  prev_din_reg,  prev_din_next;
    stamp_t               prev_dout_reg, prev_dout_next;
    stamp_t               prev_pout_reg, prev_pout_next;

    logic [RAW_BITS-1:0] dts;
    logic [RAW_BITS-1:0] pts;
    raw_diff_t           diff;
    logic [RAW_BITS:0]   mag;
    logic                too_big;
    stamp_t              step;
    stamp_t              good_step;
    raw_diff_t           gap;
    stamp_t              gap_use;
    stamp_t              d_cand;
    stamp_t              p_cand;
    stamp_t              d_out;
    stamp_t              p_out;

    assign dts       = item.decode_time;
    assign pts       = (item.present_time == '0) ? item.decode_time : item.present_time;
    assign diff      = raw_diff_t'({1'b0, dts}) - raw_diff_t'({1'b0, prev_raw_reg});
    assign mag       = diff[RAW_BITS] ? (RAW_BITS+1)'(-diff) : (RAW_BITS+1)'(diff);
    assign too_big   = mag > (RAW_BITS+1)'(cfg.max_jump);
    assign good_step = STAMP_BITS'(last_good_reg);
    assign gap       = raw_diff_t'({1'b0, pts}) - raw_diff_t'({1'b0, dts});

    always_comb
    begin
        step           = '0;
        last_good_next = last_good_reg;
        if (prev_raw_reg == '0) begin
            step = '0;
        end else if (!diff[RAW_BITS]) begin
            if (too_big) begin
                step = good_step;
            end else begin
                step           = stamp_t'(diff);
                last_good_next = diff[JUMP_BITS-1:0];
            end
        end else if (!cfg.allow_rollback || too_big) begin
            step = good_step;
        end else begin
            step = stamp_t'(diff);
        end
    end

    always_comb
    begin
        prev_raw_next  = prev_raw_reg;
        running_next   = running_reg;
        prev_din_next  = prev_din_reg;
        prev_dout_next = prev_dout_reg;
        prev_pout_next = prev_pout_reg;
        d_cand         = running_reg;
        gap_use        = '0;
        p_cand         = '0;
        d_out          = '0;
        p_out          = '0;
        if (cfg.playback) begin
            d_out         = STAMP_BITS'(dts);
            p_out         = STAMP_BITS'(pts);
            running_next  = STAMP_BITS'(dts);
            prev_din_next = dts;
        end else begin
            if (prev_din_reg != dts) begin
                d_cand        = sat_add(running_reg, step);
                running_next  = d_cand;
                prev_din_next = dts;
                prev_raw_next = dts;
            end
            if (gap <= GAP_HI && gap >= GAP_LO) begin
                gap_use = stamp_t'(gap);
            end
            p_cand = sat_add(d_cand, gap_use);
            if (d_cand < prev_dout_reg) begin
                d_out = prev_dout_reg;
                p_out = prev_pout_reg;
            end else begin
                d_out          = d_cand;
                p_out          = p_cand;
                prev_dout_next = d_cand;
                prev_pout_next = p_cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_raw_reg  <= '0;
            last_good_reg <= JUMP_BITS'(1);
            running_reg   <= '0;
            prev_din_reg  <= '0;
            prev_dout_reg <= '0;
            prev_pout_reg <= '0;
        end else if (advance) begin
            prev_raw_reg  <= prev_raw_next;
            running_reg   <= running_next;
            prev_din_reg  <= prev_din_next;
            prev_dout_reg <= prev_dout_next;
            prev_pout_reg <= prev_pout_next;
            if (!cfg.playback && prev_din_reg != dts) begin
                last_good_reg <= last_good_next;
            end
        end
    end

    assign result.decode_out  = to_out(d_out);
    assign result.present_out = to_out(p_out);

    a_dout_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (prev_dout_reg >= $past(prev_dout_reg)))
        else $error("revised decode history went backward");

    a_history_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(prev_raw_reg) && $stable(running_reg) && $stable(prev_dout_reg)))
        else $error("stamp history changed without an item");

    a_playback_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cfg.playback) |=> $stable(prev_raw_reg) && $stable(last_good_reg))
        else $error("playback item touched the increment history");

endmodule

// ===== verif/media_timestamp_reviser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media timestamp reviser testbench
// Drives frame timestamp items through the reviser under several register
// settings and handshake stall patterns. Each result is checked against fixed
// expected values or a behavioral timestamp revision model kept in this bench.
// ----------------------------------------------------------------------------
module media_timestamp_reviser_tb;

    import mtr_pkg::*;

    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 4;
    localparam longint STAMP_HI       = (longint'(1) <<< (STAMP_BITS - 1)) - 1;
    localparam longint STAMP_LO       = -STAMP_HI - 1;

    typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        cfg_index_t               reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        in_item_t                 item;
        bit                       typed;
        out_item_t                want;
    } plan_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    in_item_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    bit        row_typed = 1'b0;
    out_item_t row_want  = '0;

    bit                   shadow_playback;
    bit                   shadow_rollback;
    logic [JUMP_BITS-1:0] shadow_max_jump;
    logic [31:0]          last_seen_dts;
    longint               good_increment;
    longint               rel_stamp;
    logic [31:0]          last_dts_in;
    longint               held_dts_out;
    longint               held_pts_out;

    out_item_t revised_q[$];
    plan_row_t directed_plan[$];
    int        mismatches    = 0;
    int        quiet_cycles  = 0;
    int        stall_pct     = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    logic [31:0] stream_dts  = 0;

    media_timestamp_reviser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic longint clamp_add(input longint a, input longint d);
        longint base;
        base = a;
        if (base > STAMP_HI)
        begin
            base = STAMP_HI;
        end
        if (base < STAMP_LO)
        begin
            base = STAMP_LO;
        end
        if (d > 0 && base > STAMP_HI - d)
        begin
            return STAMP_HI;
        end
        if (d < 0 && base < STAMP_LO - d)
        begin
            return STAMP_LO;
        end
        return base + d;
    endfunction

    function automatic longint next_increment(input logic [31:0] dts);
        longint d;
        if (last_seen_dts == 0)
        begin
            if (dts != 0)
            begin
                last_seen_dts = dts;
            end
            return 0;
        end
        d = longint'(dts) - longint'(last_seen_dts);
        last_seen_dts = dts;
        if (d >= 0)
        begin
            if (d > longint'(shadow_max_jump))
            begin
                return good_increment;
            end
            good_increment = d;
            return d;
        end
        if (!shadow_rollback || -d > longint'(shadow_max_jump))
        begin
            return good_increment;
        end
        return d;
    endfunction

    function automatic out_item_t revise_stamps(input in_item_t it);
        out_item_t   res;
        logic [31:0] dts;
        logic [31:0] pts;
        longint      dout;
        longint      pout;
        longint      gap;
        dts = it.decode_time;
        pts = (it.present_time == 0) ? dts : it.present_time;
        if (shadow_playback)
        begin
            dout        = longint'(dts);
            pout        = longint'(pts);
            rel_stamp   = dout;
            last_dts_in = dts;
        end
        else
        begin
            gap = longint'(pts) - longint'(dts);
            if (last_dts_in != dts)
            begin
                rel_stamp   = clamp_add(rel_stamp, next_increment(dts));
                last_dts_in = dts;
            end
            dout = rel_stamp;
            if (gap > GAP_LIMIT || gap < -GAP_LIMIT)
            begin
                gap = 0;
            end
            pout = clamp_add(dout, gap);
            if (dout < held_dts_out)
            begin
                dout = held_dts_out;
                pout = held_pts_out;
            end
            else
            begin
                held_dts_out = dout;
                held_pts_out = pout;
            end
        end
        res.decode_out  = dout[OUT_BITS-1:0];
        res.present_out = pout[OUT_BITS-1:0];
        return res;
    endfunction

    initial
    begin
        shadow_playback = 1'b0;
        shadow_rollback = 1'b0;
        shadow_max_jump = JUMP_BITS'(JUMP_RESET);
        last_seen_dts   = 0;
        good_increment  = 1;
        rel_stamp       = 0;
        last_dts_in     = 0;
        held_dts_out    = 0;
        held_pts_out    = 0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t pred;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PLAYBACK:       shadow_playback = cfg_wdata[0];
                    CFG_ALLOW_ROLLBACK: shadow_rollback = cfg_wdata[0];
                    CFG_MAX_JUMP:       shadow_max_jump = cfg_wdata[JUMP_BITS-1:0];
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                pred = revise_stamps(in_data);
                revised_q.push_back(row_typed ? row_want : pred);
            end
            if (out_valid && !out_stall)
            begin
                if (revised_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result dts=%0d pts=%0d",
                                              out_data.decode_out, out_data.present_out));
                end
                else
                begin
                    want = revised_q.pop_front();
                    if (out_data.decode_out !== want.decode_out)
                    begin
                        report_mismatch($sformatf("decode_out %0d, expected %0d",
                                                  out_data.decode_out, want.decode_out));
                    end
                    if (out_data.present_out !== want.present_out)
                    begin
                        report_mismatch($sformatf("present_out %0d, expected %0d",
                                                  out_data.present_out, want.present_out));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (revised_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= it;
        row_typed <= typed;
        row_want  <= want;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    function automatic void add_frame(input logic [31:0] dts, input logic [31:0] pts);
        plan_row_t row;
        row.kind    = ROW_ITEM;
        row.reg_idx = CFG_PLAYBACK;
        row.reg_val = '0;
        row.item    = '{decode_time: dts, present_time: pts};
        row.typed   = 1'b0;
        row.want    = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void add_checked(input logic [31:0] dts, input logic [31:0] pts,
                                        input longint dout, input longint pout);
        add_frame(dts, pts);
        directed_plan[$].typed            = 1'b1;
        directed_plan[$].want.decode_out  = dout[OUT_BITS-1:0];
        directed_plan[$].want.present_out = pout[OUT_BITS-1:0];
    endfunction

    function automatic void add_reg(input cfg_index_t idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
        plan_row_t row;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic in_item_t next_frame();
        in_item_t    it;
        int          pick;
        logic [31:0] dts;
        logic [31:0] pts;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if ($urandom_range(19) != 0)
            begin
                case ($urandom_range(4))
                    0:       stream_dts += 33;
                    1:       stream_dts += 40;
                    2:       stream_dts += 20;
                    3:       stream_dts += 17;
                    default: stream_dts += $urandom_range(1, 120);
                endcase
            end
            dts = stream_dts;
            case ($urandom_range(9))
                0, 1:    pts = 0;
                2:       pts = dts - $urandom_range(0, 500);
                default: pts = dts + $urandom_range(0, 500);
            endcase
        end
        else if (pick < 80)
        begin
            case ($urandom_range(3))
                0:       stream_dts += $urandom_range(301, 2000000);
                1:       stream_dts -= $urandom_range(1, 600);
                2:       stream_dts -= $urandom_range(601, 3000000);
                default: stream_dts += $urandom_range(1, 1048575);
            endcase
            dts = stream_dts;
            pts = $urandom_range(1) ? 32'd0 : dts + $urandom_range(0, 200);
        end
        else if (pick < 88)
        begin
            stream_dts += 40;
            dts = stream_dts;
            pts = $urandom_range(1) ? dts + $urandom_range(501, 200000)
                                    : dts - $urandom_range(501, 200000);
        end
        else if (pick < 92)
        begin
            dts = 0;
            pts = $urandom_range(1) ? 32'd0 : $urandom;
        end
        else
        begin
            dts = $urandom;
            pts = $urandom;
            if ($urandom_range(1))
            begin
                stream_dts = dts;
            end
        end
        it.decode_time  = dts;
        it.present_time = pts;
        return it;
    endfunction

    task automatic run_phase(input bit playback, input bit rollback,
                             input logic [JUMP_BITS-1:0] max_jump, input int sender_pct,
                             input int receiver_pct, input int count,
                             input bit hold_off, input bit pause);
        write_reg(CFG_PLAYBACK, CFG_DATA_BITS'(playback));
        write_reg(CFG_ALLOW_ROLLBACK, CFG_DATA_BITS'(rollback));
        write_reg(CFG_MAX_JUMP, CFG_DATA_BITS'(max_jump));
        stall_pct  = receiver_pct;
        stream_dts = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000);
        for (int i = 0; i < count; i++)
        begin
            if (hold_off && i == count / 3)
            begin
                hold_requests++;
            end
            if (pause && i == count / 2)
            begin
                drain_results();
            end
            send_item(next_frame(), 1'b0, '0, (hold_off && hold_left > 0) ? 0 : sender_pct);
        end
    endtask

    initial
    begin
        add_checked(1000, 0, 0, 0);
        add_checked(1040, 1100, 40, 100);
        add_checked(1040, 0, 40, 40);
        add_checked(1080, 2000, 80, 80);
        add_checked(5000, 5500, 120, 620);
        add_checked(4990, 4490, 160, -340);
        add_checked(0, 0, 200, 200);
        add_checked(32'hFFFF_FFFF, 32'hFFFF_FFFF, 200, 200);
        add_checked(32'hFFFF_FFFF, 1, 200, 200);
        add_checked(1, 32'hFFFF_FFFF, 240, 240);
        add_reg(CFG_ALLOW_ROLLBACK, CFG_DATA_BITS'(1));
        add_frame(1100, 1150);
        add_frame(1050, 0);
        add_frame(1400, 1900);
        add_reg(CFG_MAX_JUMP, CFG_DATA_BITS'(0));
        add_frame(1400, 0);
        add_frame(1401, 1401);
        add_reg(CFG_MAX_JUMP, 20'hFFFFF);
        add_frame(1401 + 1048575, 0);
        add_frame(1401, 1000);
        add_reg(CFG_PLAYBACK, CFG_DATA_BITS'(1));
        add_checked(7, 0, 7, 7);
        add_checked(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        add_reg(CFG_PLAYBACK, CFG_DATA_BITS'(0));
        add_frame(100, 0);
        add_frame(140, 600);
        add_reg(CFG_ALLOW_ROLLBACK, CFG_DATA_BITS'(0));
        add_reg(CFG_MAX_JUMP, CFG_DATA_BITS'(JUMP_RESET));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_REG)
            begin
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end
            else
            begin
                send_item(directed_plan[i].item, directed_plan[i].typed,
                          directed_plan[i].want, 0);
            end
        end

        run_phase(1'b0, 1'b0, JUMP_BITS'(JUMP_RESET), 0, 0, 240, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, JUMP_BITS'(JUMP_RESET), 70, 0, 240, 1'b0, 1'b1);
        run_phase(1'b0, 1'b1, JUMP_BITS'(0), 0, 70, 240, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 20'hFFFFF, 15, 15, 240, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, JUMP_BITS'(JUMP_RESET), 0, 0, 160, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 20'hFFFFF, 70, 0, 240, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, JUMP_BITS'($urandom_range(1, 2000)), 0, 70, 240, 1'b1, 1'b0);
        run_phase(1'b0, 1'b0, JUMP_BITS'($urandom_range(20, 2000)), 15, 15, 330, 1'b0, 1'b0);

        drain_results();
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
